@@ rtl/dfmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dfmc_pkg
// Shared types, codes and constants of the duplicate-message cache.
// ----------------------------------------------------------------------------
package dfmc_pkg;

    // Bound on the slot count; a 7-bit capacity lets at most 127 hold entries.
    localparam int MAX_SLOTS = 128;

    localparam int DEF_DEPTH         = 64;
    localparam int DEF_KEY_BITS      = 64;
    localparam int DEF_NEIGHBOR_BITS = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOD     = 2'd2;

    localparam logic [6:0] CAPACITY_RST  = 7'd64;
    localparam logic [7:0] DIFFUSION_RST = 8'd1;
    localparam logic [7:0] FLOOD_RST     = 8'd0;

    localparam logic [1:0] ACT_FLOOD   = 2'd0;
    localparam logic [1:0] ACT_DIFFUSE = 2'd1;

    localparam logic [7:0]  ABSENT_TYPE   = 8'hFF;
    localparam logic [31:0] ABSENT_SENDER = 32'hFFFF_FFFB;

    typedef enum logic [1:0] {
        KIND_FLOOD,
        KIND_DIFFUSE,
        KIND_LOOKUP
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_RESOLVE
    } t_back_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] digest_key;
        logic [7:0]  message_type;
        logic [31:0] sender;
        logic [31:0] neighbor_mask;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [7:0]  stored_type;
        logic [31:0] stored_sender;
        logic [31:0] stored_neighbors;
    } t_out_item;

    // Classified item as it waits in the queue.
    typedef struct packed {
        t_kind       kind;
        logic [63:0] key;
        logic [7:0]  mtype;
        logic [31:0] sender;
        logic [31:0] nbr;
    } t_work;

    typedef struct packed {
        logic [6:0] capacity;        // live capacity, 1 .. min(slot count, 127)
        logic [7:0] diffusion_code;
        logic [7:0] flood_code;
        logic       clear;
    } t_cfg;

    function automatic int slot_count(input int depth);
        return (depth < MAX_SLOTS) ? depth : MAX_SLOTS;
    endfunction

endpackage

@@ rtl/dfmc_ram.sv @@
// ----------------------------------------------------------------------------
// dfmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dfmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dfmc_front.sv @@
// ----------------------------------------------------------------------------
// dfmc_front
// Accept input items, classify the action, mask key and bitmap, and hold
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dfmc_front import dfmc_pkg::*; #(
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int NEIGHBOR_BITS = DEF_NEIGHBOR_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_head_valid,
    output t_work    o_head,
    input  logic     i_pop
);

    localparam int NBR_W = (NEIGHBOR_BITS < 32) ? NEIGHBOR_BITS : 32;
    localparam logic [63:0] KEY_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF << KEY_BITS);
    localparam logic [31:0] NBR_MASK = ~(32'hFFFF_FFFF << NBR_W);

    t_work      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_work      w_item;
    logic       w_push;

    always_comb begin
        w_item.key    = i_in_data.digest_key & KEY_MASK;
        w_item.mtype  = i_in_data.message_type;
        w_item.sender = i_in_data.sender;
        unique case (i_in_data.action)
            ACT_FLOOD: begin
                w_item.kind = KIND_FLOOD;
                w_item.nbr  = '0;
            end
            ACT_DIFFUSE: begin
                w_item.kind = KIND_DIFFUSE;
                w_item.nbr  = i_in_data.neighbor_mask & NBR_MASK;
            end
            default: begin
                w_item.kind = KIND_LOOKUP;
                w_item.nbr  = '0;
            end
        endcase
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ rtl/dfmc_back.sv @@
// ----------------------------------------------------------------------------
// dfmc_back
// Scan the stored keys one slot a cycle, then apply the insert or the type
// rewrite that the action calls for and register the result.
// ----------------------------------------------------------------------------
module dfmc_back import dfmc_pkg::*; #(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int NEIGHBOR_BITS = DEF_NEIGHBOR_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_head_valid,
    input  t_work     i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int SLOTS  = slot_count(DEPTH);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NBR_W  = (NEIGHBOR_BITS < 32) ? NEIGHBOR_BITS : 32;
    localparam int DATA_W = 8 + 32 + NBR_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    t_back_state r_state, n_state;
    t_work       r_work;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic              r_cmp_v;
    logic              r_found;
    logic [SLOT_W-1:0] r_hit;
    logic [SLOTS-1:0]  r_valid;
    logic [SLOT_W-1:0] r_oldest;
    logic [6:0]        r_fill;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [KEY_BITS-1:0] w_key_rdata;
    logic [DATA_W-1:0]   w_data_rdata;
    logic [7:0]          w_rd_type;
    logic [31:0]         w_rd_sender;
    logic [NBR_W-1:0]    w_rd_nbr;
    logic [7:0]          w_upd_type;
    logic                w_out_free;
    logic                w_commit;
    logic                w_insert;
    logic                w_key_we;
    logic                w_data_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic                w_hit;
    logic                w_full;
    logic [7:0]          w_sum;
    logic [7:0]          w_cap8;
    logic [SLOT_W-1:0]   w_pos;
    logic [SLOT_W-1:0]   w_oldest_next;
    t_out_item           w_result;

    dfmc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_waddr),
        .i_wdata (r_work.key[KEY_BITS-1:0]),
        .i_raddr (r_idx),
        .o_rdata (w_key_rdata)
    );

    dfmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_hit),
        .o_rdata (w_data_rdata)
    );

    assign w_rd_type   = w_data_rdata[DATA_W-1 -: 8];
    assign w_rd_sender = w_data_rdata[NBR_W +: 32];
    assign w_rd_nbr    = w_data_rdata[NBR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_head_valid) n_state = ST_SCAN;
            ST_SCAN:    if (r_idx == LAST_SLOT) n_state = ST_DRAIN;
            ST_DRAIN:   n_state = ST_FETCH;
            ST_FETCH:   n_state = ST_RESOLVE;
            ST_RESOLVE: if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_pop    = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_pop    = i_head_valid;
            ST_RESOLVE: w_commit = w_out_free;
            default: ;
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_hit = r_cmp_v && r_valid[r_cmp_idx] && (w_key_rdata == r_work.key[KEY_BITS-1:0]);

    // Ring position of a new entry
    always_comb begin
        w_cap8 = {1'b0, i_cfg.capacity};
        w_full = (r_fill >= i_cfg.capacity);
        w_sum  = 8'(r_oldest) + {1'b0, r_fill};
        if (w_sum >= w_cap8) begin
            w_sum = w_sum - w_cap8;
        end
        w_pos = w_full ? r_oldest : w_sum[SLOT_W-1:0];
        w_oldest_next = ((8'(r_oldest) + 8'd1) == w_cap8) ? '0 : r_oldest + SLOT_W'(1);
    end

    always_comb begin
        w_upd_type = w_rd_type;
        if (r_work.kind == KIND_FLOOD && w_rd_type == i_cfg.diffusion_code) begin
            w_upd_type = i_cfg.flood_code;
        end
        w_insert  = w_commit && !r_found && (r_work.kind != KIND_LOOKUP);
        w_key_we  = w_insert;
        w_data_we = w_insert || (w_commit && r_found);
        w_waddr   = r_found ? r_hit : w_pos;
        w_wdata   = r_found ? {w_upd_type, w_rd_sender, w_rd_nbr}
                            : {r_work.mtype, r_work.sender, r_work.nbr[NBR_W-1:0]};

        w_result.found = r_found;
        if (r_found) begin
            w_result.stored_type      = w_upd_type;
            w_result.stored_sender    = w_rd_sender;
            w_result.stored_neighbors = 32'(w_rd_nbr);
        end else if (r_work.kind != KIND_LOOKUP) begin
            w_result.stored_type      = r_work.mtype;
            w_result.stored_sender    = r_work.sender;
            w_result.stored_neighbors = 32'(r_work.nbr[NBR_W-1:0]);
        end else begin
            w_result.stored_type      = ABSENT_TYPE;
            w_result.stored_sender    = ABSENT_SENDER;
            w_result.stored_neighbors = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head;
        end
        r_cmp_idx <= r_idx;
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= '0;
            r_valid     <= '0;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= (r_state == ST_SCAN);
            if (o_pop) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (w_hit) begin
                r_found <= 1'b1;
                r_hit   <= r_cmp_idx;
            end
            if (i_cfg.clear) begin
                r_valid  <= '0;
                r_oldest <= '0;
                r_fill   <= '0;
            end else if (w_insert) begin
                r_valid[w_pos] <= 1'b1;
                if (w_full) begin
                    r_oldest <= w_oldest_next;
                end else begin
                    r_fill <= r_fill + 7'd1;
                end
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/dedup_fifo_message_cache_top.sv @@
// ----------------------------------------------------------------------------
// dedup_fifo_message_cache_top
// Duplicate-message cache keyed by a message digest, first-in first-out
// eviction at a programmable capacity.
// ----------------------------------------------------------------------------
// Each input transfer is a flood-and-prune insert, an adaptive-diffusion
// insert or a lookup of a digest key, and each one produces exactly one
// output transfer: whether the key was stored before, and the stored type,
// sender and neighbor bitmap after the action (0xFF, 0xFFFFFFFB and zero for
// an absent key). The front end classifies items into a two-entry queue, so
// up to two items are taken while the back end is busy. The back end
// compares the key against one stored slot per cycle through the key RAM's
// single read port, with SLOTS = min(DEPTH, 128). The back end takes the item
// from the queue, scans the SLOTS slots, then drains the last compare,
// fetches the hit entry and resolves the result. It takes the next item
// only once the current result has been resolved, so items do not overlap
// in the back end. A stalled output holds the back end in its resolve
// step until the pending result is taken. Writing the capacity register
// empties the store in the same cycle; no clearing pass is needed since
// only valid flags are cleared.
// ----------------------------------------------------------------------------
module dedup_fifo_message_cache_top import dfmc_pkg::*; #(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int NEIGHBOR_BITS = DEF_NEIGHBOR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input channel
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_in_stall,
    // Output channel
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SLOTS = slot_count(DEPTH);

    logic [6:0] r_capacity;
    logic [7:0] r_diffusion_code;
    logic [7:0] r_flood_code;
    t_cfg       w_cfg;
    logic       w_head_valid;
    t_work      w_head;
    logic       w_pop;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity       <= CAPACITY_RST;
            r_diffusion_code <= DIFFUSION_RST;
            r_flood_code     <= FLOOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAPACITY:  r_capacity       <= i_cfg_data[6:0];
                REG_DIFFUSION: r_diffusion_code <= i_cfg_data;
                REG_FLOOD:     r_flood_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Live capacity: zero acts as one, anything above the slot count saturates.
    always_comb begin
        if (r_capacity == 7'd0) begin
            w_cfg.capacity = 7'd1;
        end else if (int'(r_capacity) > SLOTS) begin
            w_cfg.capacity = 7'(SLOTS);
        end else begin
            w_cfg.capacity = r_capacity;
        end
        w_cfg.diffusion_code = r_diffusion_code;
        w_cfg.flood_code     = r_flood_code;
        // Empty the store at the same edge as the capacity write.
        w_cfg.clear          = i_cfg_we && (i_cfg_index == REG_CAPACITY);
    end

    dfmc_front #(
        .KEY_BITS      (KEY_BITS),
        .NEIGHBOR_BITS (NEIGHBOR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    dfmc_back #(
        .DEPTH         (DEPTH),
        .KEY_BITS      (KEY_BITS),
        .NEIGHBOR_BITS (NEIGHBOR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
